// File: rtl/slt_pkg.sv
package slt_pkg;

    localparam int KwBufLen   = 7;
    localparam int LenBits    = 16;
    localparam int QueueDepth = 4;

    localparam logic [LenBits-1:0] LEN_MAX = '1;

    // token kinds
    localparam logic [5:0] K_EOF   = 6'd0;
    localparam logic [5:0] K_DOT   = 6'd6;
    localparam logic [5:0] K_SPACE = 6'd21;
    localparam logic [5:0] K_IDENT = 6'd22;
    localparam logic [5:0] K_INT   = 6'd23;
    localparam logic [5:0] K_REAL  = 6'd24;
    localparam logic [5:0] K_KW0   = 6'd25;
    localparam logic [5:0] K_ERROR = 6'd41;

    // scan modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_OP     = 3'd1;
    localparam logic [2:0] M_IDENT  = 3'd2;
    localparam logic [2:0] M_INT    = 3'd3;
    localparam logic [2:0] M_INTDOT = 3'd4;
    localparam logic [2:0] M_REAL   = 3'd5;
    localparam logic [2:0] M_ERR    = 3'd6;

    localparam logic [15:0][55:0] KW_TXT = '{
        56'("mut"), 56'("out"), 56'("in"), 56'("uniform"),
        56'("false"), 56'("true"), 56'("fn"), 56'("for"),
        56'("while"), 56'("return"), 56'("else"), 56'("if"),
        56'("let"), 56'("struct"), 56'("and"), 56'("or")
    };
    localparam logic [15:0][2:0] KW_LEN = '{
        3'd3, 3'd3, 3'd2, 3'd7, 3'd5, 3'd4, 3'd2, 3'd3,
        3'd5, 3'd6, 3'd4, 3'd2, 3'd3, 3'd6, 3'd3, 3'd2
    };

    typedef struct packed {
        logic [5:0]         kind;
        logic [31:0]        start;
        logic [15:0]        len;
    } t_tok;

    typedef struct packed {
        t_tok [2:0]  toks;
        logic [1:0]  cnt;
        logic [31:0] line;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            "{": k = 6'd1;  "}": k = 6'd2;  "(": k = 6'd3;  ")": k = 6'd4;
            ",": k = 6'd5;  ".": k = 6'd6;  "-": k = 6'd7;  "+": k = 6'd8;
            ";": k = 6'd9;  ":": k = 6'd10; "*": k = 6'd11; "/": k = 6'd12;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            "!": k = 6'd13; "=": k = 6'd15; "<": k = 6'd17; ">": k = 6'd19;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [KwBufLen-1:0][7:0] chars,
                                           input logic [LenBits-1:0] run);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int i = 0; i < 16; i++) begin
            hit = (run == LenBits'(KW_LEN[i]));
            for (int j = 0; j < KwBufLen; j++) begin
                if (j < int'(KW_LEN[i]) &&
                    chars[j] != KW_TXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                k = K_KW0 + 6'(i);
            end
        end
        return k;
    endfunction

endpackage

// File: rtl/slt_in_if.sv
interface slt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_source;

    modport source (output valid, output char_byte, output end_of_source, input ready);
    modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

// File: rtl/slt_out_if.sv
interface slt_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] token_line;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_line, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_line, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

// File: rtl/slt_front.sv
module slt_front import slt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_char,
    input  logic        i_end,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_push,
    output t_bundle     o_bundle
);

    logic                       r_ws_en, n_ws_en;
    logic [15:0]                r_first, n_first;
    logic [31:0]                r_line, n_line;
    logic [31:0]                r_off, n_off;
    logic [31:0]                r_begin, n_begin;
    logic [2:0]                 r_mode, n_mode;
    logic [5:0]                 r_pend, n_pend;
    logic [LenBits-1:0]         r_run, n_run;
    logic [KwBufLen-1:0][7:0]   r_kw, n_kw;

    t_tok [2:0] toks;
    logic [1:0] cnt;
    logic       consumed;
    logic [7:0] b;
    logic [5:0] pk;
    logic [5:0] ok;

    function automatic t_tok mk(input logic [5:0] k, input logic [31:0] s,
                                input logic [LenBits-1:0] l);
        t_tok t;
        t.kind  = k;
        t.start = s;
        t.len   = l;
        return t;
    endfunction

    always_comb begin
        n_ws_en  = r_ws_en;
        n_first  = r_first;
        n_line   = r_line;
        n_off    = r_off;
        n_begin  = r_begin;
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_run    = r_run;
        n_kw     = r_kw;
        toks     = '0;
        cnt      = 2'd0;
        consumed = 1'b0;
        b        = i_char;
        pk       = punct_kind(i_char);
        ok       = op_kind(i_char);

        if (i_cfg_we) begin
            if (i_cfg_idx) begin
                n_first = i_cfg_data;
            end else begin
                n_ws_en = i_cfg_data[0];
            end
        end

        if (!i_end) begin
            case (r_mode)
                M_ERR: consumed = 1'b1;
                M_OP: begin
                    if (b == "=") begin
                        toks[cnt] = mk(r_pend + 6'd1, r_begin, LenBits'(2));
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                        consumed = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(b) || is_digit(b) || b == "_") begin
                        if (r_run < LenBits'(KwBufLen)) begin
                            n_kw[r_run[2:0]] = b;
                        end
                        if (r_run != LEN_MAX) n_run = r_run + 1'b1;
                        consumed = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit(b)) begin
                        if (r_run != LEN_MAX) n_run = r_run + 1'b1;
                        consumed = 1'b1;
                    end else if (b == ".") begin
                        if (r_run != LEN_MAX) n_run = r_run + 1'b1;
                        n_mode = M_INTDOT;
                        consumed = 1'b1;
                    end
                end
                M_INTDOT, M_REAL: begin
                    if (is_digit(b)) begin
                        if (r_run != LEN_MAX) n_run = r_run + 1'b1;
                        n_mode = M_REAL;
                        consumed = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // flush pending token
        if (i_end || !consumed) begin
            case (r_mode)
                M_OP: begin
                    toks[cnt] = mk(r_pend, r_begin, LenBits'(1));
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
                M_IDENT: begin
                    toks[cnt] = mk((r_run > LenBits'(KwBufLen)) ? K_IDENT
                                   : kw_kind(r_kw, r_run), r_begin, r_run);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
                M_INT: begin
                    toks[cnt] = mk(K_INT, r_begin, r_run);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
                M_REAL: begin
                    toks[cnt] = mk(K_REAL, r_begin, r_run);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
                M_INTDOT: begin
                    toks[cnt] = mk(K_INT, r_begin,
                                   (r_run != LEN_MAX) ? r_run - 1'b1 : LEN_MAX);
                    cnt = cnt + 2'd1;
                    toks[cnt] = mk(K_DOT, r_off - 32'd1, LenBits'(1));
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
                default: ;
            endcase
        end

        if (i_end) begin
            toks[cnt] = mk(K_EOF, r_off, '0);
            cnt = cnt + 2'd1;
            n_line  = {16'd0, r_first};
            n_off   = '0;
            n_begin = '0;
            n_mode  = M_IDLE;
            n_pend  = '0;
            n_run   = '0;
        end else begin
            if (!consumed) begin
                n_begin = r_off;
                if (pk != 6'd0) begin
                    toks[cnt] = mk(pk, r_off, LenBits'(1));
                    cnt = cnt + 2'd1;
                end else if (ok != 6'd0) begin
                    n_pend = ok;
                    n_mode = M_OP;
                end else if (b == 8'h0a) begin
                    n_line = r_line + 32'd1;
                end else if (b == " " || b == 8'h09 || b == 8'h0d || b == 8'h00) begin
                    if (r_ws_en) begin
                        toks[cnt] = mk(K_SPACE, r_off, LenBits'(1));
                        cnt = cnt + 2'd1;
                    end
                end else if (is_digit(b)) begin
                    n_mode = M_INT;
                    n_run  = LenBits'(1);
                end else if (is_alpha(b) || b == "_") begin
                    n_mode  = M_IDENT;
                    n_run   = LenBits'(1);
                    n_kw[0] = b;
                end else begin
                    toks[cnt] = mk(K_ERROR, r_off, LenBits'(1));
                    cnt = cnt + 2'd1;
                    n_mode = M_ERR;
                end
            end
            n_off = r_off + 32'd1;
        end
    end

    assign o_push        = i_fire && (cnt != 2'd0);
    assign o_bundle.toks = toks;
    assign o_bundle.cnt  = cnt;
    assign o_bundle.line = r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws_en <= 1'b0;
            r_first <= 16'd1;
            r_line  <= 32'd1;
            r_off   <= '0;
            r_begin <= '0;
            r_mode  <= M_IDLE;
            r_pend  <= '0;
            r_run   <= '0;
        end else begin
            r_ws_en <= n_ws_en;
            r_first <= n_first;
            if (i_fire) begin
                r_line  <= n_line;
                r_off   <= n_off;
                r_begin <= n_begin;
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_run   <= n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_kw <= n_kw;
        end
    end

    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_end |=> r_off == 32'd0 && r_mode == M_IDLE)
        else $error("end beat did not rearm scanner");
    a_end_has_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_end |-> o_push && toks[cnt - 2'd1].kind == K_EOF)
        else $error("end beat without EOF token");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_ERR && i_fire && !i_end |-> !o_push)
        else $error("token emitted in error mode");

endmodule

// File: rtl/slt_queue.sv
module slt_queue import slt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_bundle o_data
);

    localparam int PtrW = $clog2(QueueDepth);

    t_bundle             r_mem [QueueDepth];
    logic [PtrW-1:0]     r_head, r_tail;
    logic [PtrW:0]       r_count;

    assign o_full  = r_count == (PtrW+1)'(QueueDepth);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_tail <= r_tail + 1'b1;
            if (i_pop) r_head <= r_head + 1'b1;
            r_count <= r_count + (PtrW+1)'(i_push) - (PtrW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_tail] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// File: rtl/slt_back.sv
module slt_back import slt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_bundle i_q_data,
    output logic    o_pop,
    slt_out_if.source out_ch
);

    logic       r_valid;
    t_bundle    r_b;
    logic [1:0] r_idx;
    logic       last;
    logic       fire;
    t_tok       cur;

    assign cur   = r_b.toks[r_idx];
    assign last  = r_idx == (r_b.cnt - 2'd1);
    assign fire  = r_valid && out_ch.ready;
    assign o_pop = i_q_valid && (!r_valid || (fire && last));

    assign out_ch.valid        = r_valid;
    assign out_ch.token_kind   = cur.kind;
    assign out_ch.token_line   = r_b.line;
    assign out_ch.token_start  = cur.start;
    assign out_ch.token_length = cur.len;
    assign out_ch.last_of_run  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (fire) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_b <= i_q_data;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx < r_b.cnt)
        else $error("token index beyond bundle");

endmodule

// File: rtl/source_lexer_tokenizer_unit.sv
// channel  | dir | beat payload
// in_ch    | in  | char_byte[7:0], end_of_source
// out_ch   | out | token_kind, token_line, token_start, token_length, last_of_run
// cfg      | in  | i_cfg_we, i_cfg_idx (0 scan_whitespace, 1 first_line), i_cfg_data[15:0]
//
// One source byte per cycle unless the queue fills; scanner state updates as a beat is taken.
// Each beat yields up to three tokens in one queue entry (4 deep), sent one per ready cycle.
// Output is limited to one token per cycle; bursts of multi-token beats fill the queue.
// in_ch.ready drops only when the queue is full. Reset is synchronous, no clearing pass.
module source_lexer_tokenizer_unit import slt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slt_in_if.sink      in_ch,
    slt_out_if.source   out_ch,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic    fire;
    logic    push;
    logic    pop;
    logic    full;
    logic    q_valid;
    t_bundle f_bundle;
    t_bundle q_bundle;

    assign in_ch.ready = !full;
    assign fire        = in_ch.valid && !full;

    slt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_char     (in_ch.char_byte),
        .i_end      (in_ch.end_of_source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_bundle   (f_bundle)
    );

    slt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_bundle),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_bundle)
    );

    slt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_bundle),
        .o_pop     (pop),
        .out_ch    (out_ch)
    );

endmodule
